// File: sv/lmhr_pkg.sv
`default_nettype none
package lmhr_pkg;

  localparam int unsigned LabelWidth = 16;
  localparam int unsigned LimitWidth = 16;

  localparam logic [LabelWidth-1:0] MATCH_LABEL_RESET = 16'd389;

  // configuration register indexes
  localparam logic REG_MATCH_LABEL = 1'b0;

  // header bytes and limits
  localparam logic [7:0] SEQ_TAG_BYTE = 8'h30;
  localparam logic [4:0] INT_TAG_CODE = 5'h02;
  localparam logic [7:0] RES_TAG_BYTE = 8'h02;
  localparam logic [1:0] APP_CLASS    = 2'b01;
  localparam logic [4:0] MAX_OP_TAG   = 5'd25;
  localparam logic [6:0] MAX_INT_LEN  = 7'd4;
  localparam logic [2:0] MIN_START    = 3'd7;
  localparam logic [15:0] MIN_RESET   = 16'd7;

  // one payload byte request
  typedef struct packed {
    logic [7:0]            data_byte;
    logic [LimitWidth-1:0] record_limit;
    logic                  last_byte;
  } step_t;

  // running minimum plus a signed amount, clamped to 0..65535
  function automatic logic [15:0] grow(input logic [15:0] cur, input logic signed [8:0] amt);
    logic signed [17:0] m;
    m = $signed({2'b00, cur}) + 18'(amt);
    if (m < 18'sd0) begin
      grow = 16'd0;
    end else if (m > 18'sd65535) begin
      grow = 16'hFFFF;
    end else begin
      grow = m[15:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/ldap_message_header_recognizer_top.sv
`default_nettype none
// LDAP message header recognizer. Payload bytes enter one per request on the
// input channel together with the record limit and a last-byte flag; on the
// byte flagged last the block delivers one result request carrying
// match_label when the bytes opened a BER-encoded LDAP message (sequence tag,
// length, message-id integer, application-class operation tag, and for
// responses a following integer tag) and the payload held at least seven
// bytes, and 0 otherwise. The parser then returns to its start state for the
// next payload. Bytes that are not last produce no result. The block takes one
// byte every cycle while the input is not stalled: a byte is registered at the
// input, then the header state machine updates and a last byte's result goes
// into the output register. The input stalls only when a last byte waits in
// the input register while the output register holds a stalled result.
// match_label sits at byte address 0 of the APB port (reset 389) and should
// be written only while no payload is in flight.
module ldap_message_header_recognizer_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // apb configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      data_byte,
  input  wire logic [lmhr_pkg::LimitWidth-1:0] record_limit,
  input  wire logic                            last_byte,
  // output channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [lmhr_pkg::LabelWidth-1:0] label
);
  import lmhr_pkg::*;

  logic [LabelWidth-1:0] match_label;
  logic                  s1_valid;
  step_t                 s1;
  logic                  process;
  logic                  in_take;
  logic [LabelWidth-1:0] parser_label;

  // configuration register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MATCH_LABEL) ? {16'd0, match_label} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_label <= MATCH_LABEL_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MATCH_LABEL) begin
      match_label <= pwdata[LabelWidth-1:0];
    end
  end

  // the registered byte moves on unless it needs the output register and
  // that register is still blocked
  assign process  = s1_valid && (!s1.last_byte || !out_valid || !out_stall);
  assign in_stall = s1_valid && !process;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !process);
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1.data_byte    <= data_byte;
      s1.record_limit <= record_limit;
      s1.last_byte    <= last_byte;
    end
  end

  lmhr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .en          (process),
    .step        (s1),
    .match_label (match_label),
    .label       (parser_label)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && s1.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && s1.last_byte) begin
      label <= parser_label;
    end
  end

  // a held result is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(process && s1.last_byte))
    else $error("result register overwritten while stalled");

  // stall only comes from a buffered last byte blocked at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1.last_byte && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a result appears only after a last byte was processed
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(process && s1.last_byte))
    else $error("result without a last byte");

endmodule
`default_nettype wire

// File: sv/lmhr_parser.sv
`default_nettype none
module lmhr_parser (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire lmhr_pkg::step_t                   step,
  input  wire logic [lmhr_pkg::LabelWidth-1:0]   match_label,
  output logic      [lmhr_pkg::LabelWidth-1:0]   label
);
  import lmhr_pkg::*;

  typedef enum logic [3:0] {
    PH_SEQ_TAG, PH_SEQ_LEN, PH_SEQ_SKIP, PH_INT_TAG, PH_INT_LEN, PH_INT_SKIP,
    PH_OP_TAG, PH_OP_LEN, PH_OP_SKIP, PH_RES_TAG, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {VD_UNDECIDED, VD_YES, VD_NO} verdict_t;

  phase_t      phase, phase_next;
  verdict_t    verdict, verdict_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [6:0]  skip_left, skip_left_next;
  logic [15:0] min_needed, min_needed_next;
  logic        response_op, response_op_next;

  logic [7:0]  b;
  logic [6:0]  len;
  logic [15:0] lim;
  logic [15:0] m1, m2;

  assign b   = step.data_byte;
  assign len = b[6:0];
  assign lim = step.record_limit;

  always_comb begin
    phase_next       = phase;
    verdict_next     = verdict;
    skip_left_next   = skip_left;
    min_needed_next  = min_needed;
    response_op_next = response_op;
    m1 = grow(min_needed, $signed({2'b00, len}));
    m2 = grow(m1, 9'sd2);
    unique case (phase)
      PH_SEQ_TAG: begin
        if (b != SEQ_TAG_BYTE) begin
          verdict_next = VD_NO;
          phase_next   = PH_DONE;
        end else begin
          phase_next = PH_SEQ_LEN;
        end
      end
      PH_SEQ_LEN: begin
        if (b[7]) begin
          min_needed_next = m1;
          if (lim < m1) begin
            verdict_next = VD_NO;
            phase_next   = PH_DONE;
          end else begin
            skip_left_next = len;
            phase_next     = (len != 7'd0) ? PH_SEQ_SKIP : PH_INT_TAG;
          end
        end else begin
          phase_next = PH_INT_TAG;
        end
      end
      PH_SEQ_SKIP: begin
        skip_left_next = skip_left - 7'd1;
        if (skip_left == 7'd1) phase_next = PH_INT_TAG;
      end
      PH_INT_TAG: begin
        if (b[4:0] != INT_TAG_CODE) begin
          verdict_next = VD_NO;
          phase_next   = PH_DONE;
        end else begin
          phase_next = PH_INT_LEN;
        end
      end
      PH_INT_LEN: begin
        if (len > MAX_INT_LEN) begin
          verdict_next = VD_NO;
          phase_next   = PH_DONE;
        end else begin
          min_needed_next = grow(min_needed, $signed({2'b00, len}) - 9'sd1);
          if (lim < min_needed_next) begin
            verdict_next = VD_NO;
            phase_next   = PH_DONE;
          end else begin
            skip_left_next = len;
            phase_next     = (len != 7'd0) ? PH_INT_SKIP : PH_OP_TAG;
          end
        end
      end
      PH_INT_SKIP: begin
        skip_left_next = skip_left - 7'd1;
        if (skip_left == 7'd1) phase_next = PH_OP_TAG;
      end
      PH_OP_TAG: begin
        if (b[7:6] != APP_CLASS || b[4:0] > MAX_OP_TAG) begin
          verdict_next = VD_NO;
          phase_next   = PH_DONE;
        end else begin
          response_op_next = b[0];
          phase_next       = PH_OP_LEN;
        end
      end
      PH_OP_LEN: begin
        if (b[7]) begin
          // long-form operation length is taken at once
          verdict_next = VD_YES;
          phase_next   = PH_DONE;
        end else begin
          min_needed_next = m1;
          if (lim < m1) begin
            verdict_next = VD_NO;
            phase_next   = PH_DONE;
          end else if (!response_op) begin
            verdict_next = VD_YES;
            phase_next   = PH_DONE;
          end else begin
            min_needed_next = m2;
            if (lim < m2) begin
              verdict_next = VD_NO;
              phase_next   = PH_DONE;
            end else begin
              skip_left_next = len;
              phase_next     = (len != 7'd0) ? PH_OP_SKIP : PH_RES_TAG;
            end
          end
        end
      end
      PH_OP_SKIP: begin
        skip_left_next = skip_left - 7'd1;
        if (skip_left == 7'd1) phase_next = PH_RES_TAG;
      end
      PH_RES_TAG: begin
        verdict_next = (b == RES_TAG_BYTE) ? VD_YES : VD_NO;
        phase_next   = PH_DONE;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // byte count only matters up to the minimum payload size
  assign byte_count_next = (byte_count == MIN_START) ? MIN_START : byte_count + 3'd1;

  assign label = (verdict_next == VD_YES && byte_count_next == MIN_START) ?
                 match_label : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEQ_TAG;
      verdict     <= VD_UNDECIDED;
      byte_count  <= 3'd0;
      skip_left   <= 7'd0;
      min_needed  <= MIN_RESET;
      response_op <= 1'b0;
    end else if (en) begin
      if (step.last_byte) begin
        phase       <= PH_SEQ_TAG;
        verdict     <= VD_UNDECIDED;
        byte_count  <= 3'd0;
        skip_left   <= 7'd0;
        min_needed  <= MIN_RESET;
        response_op <= 1'b0;
      end else begin
        phase       <= phase_next;
        verdict     <= verdict_next;
        byte_count  <= byte_count_next;
        skip_left   <= skip_left_next;
        min_needed  <= min_needed_next;
        response_op <= response_op_next;
      end
    end
  end

endmodule
`default_nettype wire
